// ===== design/alternating_bit_reliable_sender_defines.svh =====
// Assertion macros for the alternating bit sender checker.
// No dependencies; included by files that assert.
`ifndef ALTERNATING_BIT_RELIABLE_SENDER_DEFINES_SVH
`define ALTERNATING_BIT_RELIABLE_SENDER_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define ABRS_CHECK_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abrs check failed");

// Next-cycle implication, muted while reset is high.
`define ABRS_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abrs check failed");

// Condition that must hold in the cycle after reset.
`define ABRS_CHECK_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("abrs reset check failed");

`endif

// ===== design/abrs_pkg.sv =====
// Shared constants, codes and types of the alternating bit sender.
// No dependencies; imported by every module of the block.
package abrs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int WORD_W    = 32;
   localparam int CMD_W     = 8;
   localparam int PEND_W    = 5;
   localparam int OP_W      = 2;
   localparam int KIND_W    = 2;
   localparam int ELAPSED_W = 17;
   localparam int TIMEOUT_W = 16;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'd65536;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_POLL    = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NEW     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESEND  = 2'd2;

   // register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd2;

   localparam logic [CMD_W-1:0]     ACK_ZERO_RST = 8'd85;
   localparam logic [CMD_W-1:0]     ACK_ONE_RST  = 8'd170;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd2000;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [WORD_W-1:0] azimuth;
      logic [WORD_W-1:0] inclination;
      logic [WORD_W-1:0] roll;
      logic [WORD_W-1:0] distance;
   } reading_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      reading_type      reading;
      logic             present;
      logic [CMD_W-1:0] command;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              seq_bit;
      reading_type       words;
      logic [CMD_W-1:0]  fwd_cmd;
      logic [PEND_W-1:0] pending;
      logic              last;
   } rsp_type;

   // engine to result queue
   typedef struct packed {
      logic    push;
      rsp_type data;
   } rsp_push_type;

endpackage

// ===== design/abrs_front.sv =====
// Front end: accepts request transactions, drops unused operation codes and
// holds classified commands in a two-entry queue. Depends on abrs_pkg.
module abrs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [abrs_pkg::OP_W-1:0]        req_operation,
   input  abrs_pkg::reading_type            req_reading,
   input  logic                             req_command_present,
   input  logic [abrs_pkg::CMD_W-1:0]       req_received_command,
   output logic                             cmd_valid,
   output abrs_pkg::cmd_type                cmd_data,
   input  logic                             cmd_pop
);
   import abrs_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        known_op;
   logic        do_wr;
   logic        do_rd;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];

   // operation code 3 is taken and dropped here
   assign known_op = (req_operation == OP_ENQUEUE) || (req_operation == OP_POLL) ||
                     (req_operation == OP_TICK);
   assign do_wr    = req_push && !req_full && known_op;
   assign do_rd    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= '{op: req_operation, reading: req_reading,
                                 present: req_command_present,
                                 command: req_received_command};
      end
   end

endmodule

// ===== design/abrs_engine.sv =====
// Back end: reading queue memory, acknowledgement check, send step and
// millisecond timer; pushes results into the result queue. Depends on abrs_pkg.
module abrs_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [abrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [abrs_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                             cmd_valid,
   input  abrs_pkg::cmd_type                cmd_data,
   output logic                             cmd_pop,
   input  logic                             rsp_room,
   output abrs_pkg::rsp_push_type           rsp_out
);
   import abrs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEND = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [QPTR_W-1:0]    head_ff, head_in;
   logic [QPTR_W-1:0]    tail_ff, tail_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 await_ff, await_in;
   logic                 seq_ff, seq_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 fwd_valid_ff, fwd_valid_in;
   logic                 emit_new_ff, emit_new_in;
   logic                 emit_bit_ff, emit_bit_in;
   logic [PEND_W-1:0]    emit_pend_ff, emit_pend_in;
   logic [CMD_W-1:0]     ack0_ff, ack1_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [CMD_W-1:0]     fwd_cmd_ff;
   reading_type          cur_ff;
   reading_type          rd_data_ff;
   reading_type          mem [QUEUE_DEPTH];

   logic                 mem_we;
   logic                 mem_re;
   logic [PEND_W-1:0]    pending_now;
   logic [CMD_W-1:0]     expected_code;
   logic [CMD_W-1:0]     other_code;
   logic                 resend;
   logic                 fresh;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign pending_now   = PEND_W'({1'b0, fill_ff} + (QFILL_W + 1)'(await_ff));
   // seq_ff holds the bit of the next packet; the one just used is its inverse
   assign expected_code = seq_ff ? ack0_ff : ack1_ff;
   assign other_code    = seq_ff ? ack1_ff : ack0_ff;
   assign resend        = await_ff && (elapsed_ff > ELAPSED_W'(timeout_ff));
   assign fresh         = !await_ff && (fill_ff != '0);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      await_in     = await_ff;
      seq_in       = seq_ff;
      elapsed_in   = elapsed_ff;
      fwd_valid_in = fwd_valid_ff;
      emit_new_in  = emit_new_ff;
      emit_bit_in  = emit_bit_ff;
      emit_pend_in = emit_pend_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      cmd_pop      = 1'b0;
      rsp_out      = '0;

      case (state_ff)
         ST_IDLE: begin
            // start only with room for the two results an item can make
            if (cmd_valid && rsp_room) begin
               cmd_pop      = 1'b1;
               fwd_valid_in = 1'b0;
               case (cmd_data.op)
                  OP_ENQUEUE: begin
                     if (fill_ff < QFILL_W'(QUEUE_DEPTH)) begin
                        mem_we  = 1'b1;
                        tail_in = ptr_next(tail_ff);
                        fill_in = fill_ff + QFILL_W'(1);
                     end
                     state_in = ST_SEND;
                  end
                  OP_POLL: begin
                     if (cmd_data.present) begin
                        if (cmd_data.command == expected_code) begin
                           await_in     = 1'b0;
                           fwd_valid_in = 1'b1;
                        end else if (cmd_data.command != other_code) begin
                           fwd_valid_in = 1'b1;
                        end
                     end
                     state_in = ST_SEND;
                  end
                  OP_TICK: begin
                     if (elapsed_ff < ELAPSED_MAX) begin
                        elapsed_in = elapsed_ff + ELAPSED_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEND: begin
            if (fwd_valid_ff) begin
               rsp_out.push         = 1'b1;
               rsp_out.data.kind    = KIND_FORWARD;
               rsp_out.data.fwd_cmd = fwd_cmd_ff;
               rsp_out.data.pending = pending_now;
               rsp_out.data.last    = !(resend || fresh);
            end
            if (resend) begin
               elapsed_in   = '0;
               emit_new_in  = 1'b0;
               emit_bit_in  = ~seq_ff;
               emit_pend_in = pending_now;
               state_in     = ST_EMIT;
            end else if (fresh) begin
               // dequeue: fill drops by one and the outstanding packet adds one
               mem_re       = 1'b1;
               head_in      = ptr_next(head_ff);
               fill_in      = fill_ff - QFILL_W'(1);
               await_in     = 1'b1;
               elapsed_in   = '0;
               emit_new_in  = 1'b1;
               emit_bit_in  = seq_ff;
               emit_pend_in = PEND_W'(fill_ff);
               seq_in       = ~seq_ff;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_out.push         = 1'b1;
            rsp_out.data.kind    = emit_new_ff ? KIND_NEW : KIND_RESEND;
            rsp_out.data.seq_bit = emit_bit_ff;
            rsp_out.data.words   = emit_new_ff ? rd_data_ff : cur_ff;
            rsp_out.data.pending = emit_pend_ff;
            rsp_out.data.last    = 1'b1;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         await_ff     <= 1'b0;
         seq_ff       <= 1'b0;
         elapsed_ff   <= '0;
         fwd_valid_ff <= 1'b0;
         emit_new_ff  <= 1'b0;
         emit_bit_ff  <= 1'b0;
         emit_pend_ff <= '0;
         ack0_ff      <= ACK_ZERO_RST;
         ack1_ff      <= ACK_ONE_RST;
         timeout_ff   <= TIMEOUT_RST;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         await_ff     <= await_in;
         seq_ff       <= seq_in;
         elapsed_ff   <= elapsed_in;
         fwd_valid_ff <= fwd_valid_in;
         emit_new_ff  <= emit_new_in;
         emit_bit_ff  <= emit_bit_in;
         emit_pend_ff <= emit_pend_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ACK_ZERO: ack0_ff    <= csr_wr_data[CMD_W-1:0];
               CSR_ACK_ONE:  ack1_ff    <= csr_wr_data[CMD_W-1:0];
               CSR_TIMEOUT:  timeout_ff <= csr_wr_data[TIMEOUT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload: command byte, outstanding packet, queue memory
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         fwd_cmd_ff <= cmd_data.command;
      end
      if (state_ff == ST_EMIT && emit_new_ff) begin
         cur_ff <= rd_data_ff;
      end
      if (mem_we) begin
         mem[tail_ff] <= cmd_data.reading;
      end
      if (mem_re) begin
         rd_data_ff <= mem[head_ff];
      end
   end

endmodule

// ===== design/abrs_rsp_fifo.sv =====
// Result queue between the engine and the response ports.
// Depends on abrs_pkg.
module abrs_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  abrs_pkg::rsp_push_type push_in,
   output logic                   room,
   output logic                   empty,
   input  logic                   pop,
   output abrs_pkg::rsp_type      head
);
   import abrs_pkg::*;

   rsp_type              slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_rd;

   assign empty = (count_ff == '0);
   // two free entries: enough for every result of one transaction
   assign room  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign head  = slot_ff[rd_ptr_ff];
   assign do_rd = pop && !empty;

   always_comb begin
      wr_ptr_in = push_in.push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push_in.push) - RSP_CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slot_ff[wr_ptr_ff] <= push_in.data;
      end
   end

endmodule

// ===== design/alternating_bit_reliable_sender.sv =====
// Top level of the alternating bit sender: front end, engine, result queue.
// Depends on abrs_pkg, abrs_front, abrs_engine, abrs_rsp_fifo.
//
//   channel   ports    handshake            moves
//   request   req_*    push / full          one item: enqueue, poll or tick
//   response  rsp_*    empty / pop          one result, oldest first
//   control   csr_*    wr_en                one register write, no wait
//
// An enqueue or poll passes through the engine's start and send steps, and an emit
// step when it sends or resends a packet; a tick ends in the start step, and an unused
// code is dropped in the front end. A request is registered in the front queue before
// the engine can take it. The engine takes a command only when the result queue has
// two free entries. Reset is synchronous and needs no clearing pass; queue memory
// entries hold nothing meaningful until written.
module alternating_bit_reliable_sender (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [abrs_pkg::OP_W-1:0]       req_operation,
   input  logic [abrs_pkg::WORD_W-1:0]     req_reading_azimuth,
   input  logic [abrs_pkg::WORD_W-1:0]     req_reading_inclination,
   input  logic [abrs_pkg::WORD_W-1:0]     req_reading_roll,
   input  logic [abrs_pkg::WORD_W-1:0]     req_reading_distance,
   input  logic                            req_command_present,
   input  logic [abrs_pkg::CMD_W-1:0]      req_received_command,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [abrs_pkg::KIND_W-1:0]     rsp_result_kind,
   output logic                            rsp_packet_sequence_bit,
   output logic [abrs_pkg::WORD_W-1:0]     rsp_sent_azimuth,
   output logic [abrs_pkg::WORD_W-1:0]     rsp_sent_inclination,
   output logic [abrs_pkg::WORD_W-1:0]     rsp_sent_roll,
   output logic [abrs_pkg::WORD_W-1:0]     rsp_sent_distance,
   output logic [abrs_pkg::CMD_W-1:0]      rsp_forwarded_command,
   output logic [abrs_pkg::PEND_W-1:0]     rsp_pending_total,
   output logic                            rsp_last_of_run,
   input  logic                            csr_wr_en,
   input  logic [abrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [abrs_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import abrs_pkg::*;

   reading_type  req_reading;
   logic         cmd_valid;
   cmd_type      cmd_data;
   logic         cmd_pop;
   logic         rsp_room;
   rsp_push_type rsp_push;
   rsp_type      rsp_head;

   assign req_reading = '{azimuth: req_reading_azimuth, inclination: req_reading_inclination,
                          roll: req_reading_roll, distance: req_reading_distance};

   abrs_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_operation        (req_operation),
      .req_reading          (req_reading),
      .req_command_present  (req_command_present),
      .req_received_command (req_received_command),
      .cmd_valid            (cmd_valid),
      .cmd_data             (cmd_data),
      .cmd_pop              (cmd_pop)
   );

   abrs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .rsp_room    (rsp_room),
      .rsp_out     (rsp_push)
   );

   abrs_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_in (rsp_push),
      .room    (rsp_room),
      .empty   (rsp_empty),
      .pop     (rsp_pop),
      .head    (rsp_head)
   );

   assign rsp_result_kind         = rsp_head.kind;
   assign rsp_packet_sequence_bit = rsp_head.seq_bit;
   assign rsp_sent_azimuth        = rsp_head.words.azimuth;
   assign rsp_sent_inclination    = rsp_head.words.inclination;
   assign rsp_sent_roll           = rsp_head.words.roll;
   assign rsp_sent_distance       = rsp_head.words.distance;
   assign rsp_forwarded_command   = rsp_head.fwd_cmd;
   assign rsp_pending_total       = rsp_head.pending;
   assign rsp_last_of_run         = rsp_head.last;

endmodule

// ===== design/abrs_checker.sv =====
// Port-level checks of the alternating bit sender, bound to the top level.
// Depends on abrs_pkg and alternating_bit_reliable_sender_defines.svh.
`include "alternating_bit_reliable_sender_defines.svh"

module abrs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [abrs_pkg::KIND_W-1:0] rsp_result_kind,
   input logic                        rsp_packet_sequence_bit,
   input logic [abrs_pkg::WORD_W-1:0] rsp_sent_azimuth,
   input logic [abrs_pkg::WORD_W-1:0] rsp_sent_inclination,
   input logic [abrs_pkg::WORD_W-1:0] rsp_sent_roll,
   input logic [abrs_pkg::WORD_W-1:0] rsp_sent_distance,
   input logic [abrs_pkg::CMD_W-1:0]  rsp_forwarded_command,
   input logic                        rsp_last_of_run
);
   import abrs_pkg::*;

   logic is_forward;
   logic is_packet;
   logic packet_fields_zero;

   assign is_forward         = !rsp_empty && (rsp_result_kind == KIND_FORWARD);
   assign is_packet          = !rsp_empty && (rsp_result_kind != KIND_FORWARD);
   assign packet_fields_zero = !rsp_packet_sequence_bit && (rsp_sent_azimuth == '0) &&
                               (rsp_sent_inclination == '0) && (rsp_sent_roll == '0) &&
                               (rsp_sent_distance == '0);

   `ABRS_CHECK_RESET(a_reset_idle, clock, reset, rsp_empty && !req_full)
   `ABRS_CHECK_NEXT(a_result_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
   `ABRS_CHECK_NOW(a_forward_blank, clock, reset, is_forward, packet_fields_zero)
   `ABRS_CHECK_NOW(a_packet_blank, clock, reset, is_packet, rsp_forwarded_command == '0)
   `ABRS_CHECK_NOW(a_first_is_forward, clock, reset, !rsp_empty && !rsp_last_of_run, is_forward)

endmodule

bind alternating_bit_reliable_sender abrs_checker u_abrs_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_full                (req_full),
   .rsp_empty               (rsp_empty),
   .rsp_pop                 (rsp_pop),
   .rsp_result_kind         (rsp_result_kind),
   .rsp_packet_sequence_bit (rsp_packet_sequence_bit),
   .rsp_sent_azimuth        (rsp_sent_azimuth),
   .rsp_sent_inclination    (rsp_sent_inclination),
   .rsp_sent_roll           (rsp_sent_roll),
   .rsp_sent_distance       (rsp_sent_distance),
   .rsp_forwarded_command   (rsp_forwarded_command),
   .rsp_last_of_run         (rsp_last_of_run)
);
